// ===== rtl/nkh_pkg.sv =====
// Package: shared types, constants and mix helpers for the node key hash.
`timescale 1ns / 1ps
`default_nettype none

package nkh_pkg;

    // Stream widths
    localparam int S_TDATA_W = 56;   // key_word, byte_count, namespace, zero pad
    localparam int S_TUSER_W = 2;    // mode
    localparam int M_TDATA_W = 32;   // hash_value

    localparam int FIFO_DEPTH_DEF = 2;

    // Hash constants
    localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2    = 32'h1b873593;
    localparam logic [31:0] MIX_ADD   = 32'he6546b64;
    localparam logic [31:0] FIN_M1    = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2    = 32'hc2b2ae35;
    localparam logic [31:0] KNUTH_MUL = 32'd2654435761;

    // Input mode codes
    typedef enum logic [1:0] {
        MODE_NUMERIC = 2'd0,
        MODE_ARRAY   = 2'd1,
        MODE_ABSENT  = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    // Command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_DIRECT = 2'd0,   // finished value, send as is
        CMD_BLOCK  = 2'd1,   // non-last array word
        CMD_LAST   = 2'd2,   // last array word
        CMD_NONE   = 2'd3    // never queued
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] value;     // scrambled word, or the finished hash
        logic [15:0] ns;        // seed used if this starts a key
        logic [2:0]  count;     // bytes on last word, already saturated
    } nkh_cmd_t;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        rotl15 = {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        rotl13 = {x[18:0], x[31:19]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/node_key_hash.sv =====
// Top level of the node key hash: front end, command queue and back end.
//
// Usage:
//   Slave stream (s_*) takes one word per handshake. tuser holds the mode:
//   numeric key, byte-array word or absent array. tlast marks the final word
//   of an array key (numeric and absent words are always complete).
//   Master stream (m_*) gives one 32-bit hash per numeric word, per absent
//   word and per array key on its last word. Unused mode 3 is dropped.
// Flow:
//   The front end scrambles each array word with two registered multiplies
//   (numeric words take one, absent words none) and takes no new word until
//   it has pushed the current one into the queue. The back end folds a word
//   into the running hash as it pops it; a last word is length-folded as it
//   is popped, then goes on through the avalanche states B_FM1, B_FM2, B_OUT.
// Reset:
//   rst_n clears all control state and any key in progress; no output valid.
// Stall:
//   m_tvalid holds with m_tdata stable until m_tready. Meanwhile the front
//   end keeps accepting into the queue until it fills, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module node_key_hash #(
    parameter int FIFO_DEPTH = nkh_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [31:0] key_word, [34:32] byte_count, [50:35] namespace, [55:51] zero
    input  wire logic [nkh_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tlast,
    // [1:0] mode
    input  wire logic [nkh_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] hash_value
    output logic [nkh_pkg::M_TDATA_W-1:0]      m_tdata
);
    import nkh_pkg::*;

    logic     push, pop, full, empty, front_ready;
    nkh_cmd_t push_cmd, head;

    assign s_tready = front_ready;

    nkh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (front_ready),
        .in_mode   (s_tuser[1:0]),
        .in_word   (s_tdata[31:0]),
        .in_count  (s_tdata[34:32]),
        .in_last   (s_tlast),
        .in_ns     (s_tdata[50:35]),
        .push      (push),
        .push_cmd  (push_cmd),
        .fifo_full (full)
    );

    nkh_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    nkh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/nkh_front.sv =====
// Front end: takes input words, classifies them and pre-scrambles key data.
`timescale 1ns / 1ps
`default_nettype none

module nkh_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  in_mode,
    input  wire logic [31:0]                 in_word,
    input  wire logic [2:0]                  in_count,
    input  wire logic                        in_last,
    input  wire logic [15:0]                 in_ns,
    output logic                             push,
    output nkh_pkg::nkh_cmd_t                push_cmd,
    input  wire logic                        fifo_full
);
    import nkh_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL1 = 4'b0010,
        F_MUL2 = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t     state_reg, state_next;
    cmd_kind_t   kind_reg, kind_next;
    logic        num_reg, num_next;
    logic [31:0] val_reg, val_next;
    logic [15:0] ns_reg, ns_next;
    logic [2:0]  count_reg, count_next;

    logic [2:0]  cnt_sat;
    logic [31:0] masked;
    mode_t       mode;

    assign mode     = mode_t'(in_mode);
    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !fifo_full;
    assign push_cmd = '{kind: kind_reg, value: val_reg, ns: ns_reg, count: count_reg};

    // Saturate the tail count and mask off the bytes past it
    always_comb
    begin
        cnt_sat = (in_count > 3'd4) ? 3'd4 : in_count;
        case (cnt_sat)
            3'd1:    masked = {24'h0, in_word[7:0]};
            3'd2:    masked = {16'h0, in_word[15:0]};
            3'd3:    masked = {8'h0, in_word[23:0]};
            default: masked = in_word;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        num_next   = num_reg;
        val_next   = val_reg;
        ns_next    = ns_reg;
        count_next = count_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    ns_next    = in_ns;
                    count_next = cnt_sat;
                    unique case (mode)
                        MODE_NUMERIC:
                        begin
                            kind_next  = CMD_DIRECT;
                            num_next   = 1'b1;
                            val_next   = in_word + {16'h0, in_ns};
                            state_next = F_MUL1;
                        end
                        MODE_ARRAY:
                        begin
                            kind_next  = in_last ? CMD_LAST : CMD_BLOCK;
                            num_next   = 1'b0;
                            val_next   = in_last ? masked : in_word;
                            state_next = F_MUL1;
                        end
                        MODE_ABSENT:
                        begin
                            kind_next  = CMD_DIRECT;
                            num_next   = 1'b0;
                            val_next   = '0;
                            state_next = F_PUSH;
                        end
                        default: state_next = F_IDLE;   // unused mode: dropped
                    endcase
                end
            end
            F_MUL1:
            begin
                val_next   = val_reg * (num_reg ? KNUTH_MUL : MIX_C1);
                state_next = num_reg ? F_PUSH : F_MUL2;
            end
            F_MUL2:
            begin
                val_next   = rotl15(val_reg) * MIX_C2;
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!fifo_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        num_reg   <= num_next;
        val_reg   <= val_next;
        ns_reg    <= ns_next;
        count_reg <= count_next;
    end

    // Numeric items skip the second multiply
    a_num_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_MUL1 && num_reg) |=> (state_reg == F_PUSH))
        else $error("numeric item did not go straight to push");

    a_push_kind: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_cmd.kind != CMD_NONE))
        else $error("pushed command with no kind");

    a_mul2_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_MUL2) |=> (state_reg == F_PUSH))
        else $error("second multiply not followed by push");

endmodule

`default_nettype wire

// ===== rtl/nkh_fifo.sv =====
// Command queue between the front end and the hash back end.
`timescale 1ns / 1ps
`default_nettype none

module nkh_fifo #(
    parameter int DEPTH = nkh_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire nkh_pkg::nkh_cmd_t    push_cmd,
    output logic                      full,
    input  wire logic                 pop,
    output nkh_pkg::nkh_cmd_t         head,
    output logic                      empty
);
    import nkh_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    nkh_cmd_t      slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == FULL_CNT);
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/nkh_back.sv =====
// Back end: running hash, length fold, final avalanche and output register.
`timescale 1ns / 1ps
`default_nettype none

module nkh_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire nkh_pkg::nkh_cmd_t    head,
    input  wire logic                 empty,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [31:0]               out_data
);
    import nkh_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_FM1  = 4'b0010,
        B_FM2  = 4'b0100,
        B_OUT  = 4'b1000
    } bstate_t;

    bstate_t     state_reg, state_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] len_reg, len_next;
    logic        in_key_reg, in_key_next;
    logic [31:0] acc_reg, acc_next;
    logic        oval_reg, oval_next;
    logic [31:0] odata_reg, odata_next;

    logic        out_free;
    logic [31:0] h0, l0, bmix, h1, l1, fold;

    assign out_free  = !oval_reg || out_ready;
    assign out_valid = oval_reg;
    assign out_data  = odata_reg;

    // Seed with the namespace on the first word of a key
    always_comb
    begin
        h0   = in_key_reg ? hash_reg : {16'h0, head.ns};
        l0   = in_key_reg ? len_reg : 32'h0;
        bmix = (rotl13(h0 ^ head.value) << 2) + rotl13(h0 ^ head.value) + MIX_ADD;
        case (head.count)
            3'd4:    h1 = bmix;
            3'd0:    h1 = h0;
            default: h1 = h0 ^ head.value;
        endcase
        l1   = l0 + {29'h0, head.count};
        fold = h1 ^ l1;
    end

    always_comb
    begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        len_next    = len_reg;
        in_key_next = in_key_reg;
        acc_next    = acc_reg;
        oval_next   = oval_reg && !out_ready;
        odata_next  = odata_reg;
        pop         = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    case (head.kind)
                        CMD_DIRECT:
                        begin
                            if (out_free)
                            begin
                                pop         = 1'b1;
                                oval_next   = 1'b1;
                                odata_next  = head.value;
                                hash_next   = '0;
                                len_next    = '0;
                                in_key_next = 1'b0;
                            end
                        end
                        CMD_BLOCK:
                        begin
                            pop         = 1'b1;
                            hash_next   = bmix;
                            len_next    = l0 + 32'd4;
                            in_key_next = 1'b1;
                        end
                        CMD_LAST:
                        begin
                            pop         = 1'b1;
                            acc_next    = fold ^ (fold >> 16);
                            hash_next   = '0;
                            len_next    = '0;
                            in_key_next = 1'b0;
                            state_next  = B_FM1;
                        end
                        default: pop = 1'b1;   // never queued; drain it
                    endcase
                end
            end
            B_FM1:
            begin
                acc_next   = acc_reg * FIN_M1;
                state_next = B_FM2;
            end
            B_FM2:
            begin
                acc_next   = (acc_reg ^ (acc_reg >> 13)) * FIN_M2;
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    odata_next = acc_reg ^ (acc_reg >> 16);
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            hash_reg   <= '0;
            len_reg    <= '0;
            in_key_reg <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hash_reg   <= hash_next;
            len_reg    <= len_next;
            in_key_reg <= in_key_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        odata_reg <= odata_next;
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == B_IDLE))
        else $error("queue popped while finishing a hash");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.kind == CMD_LAST) |=> (!in_key_reg && state_reg == B_FM1))
        else $error("last word did not close the key");

    a_fm_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FM1) |=> (state_reg == B_FM2))
        else $error("avalanche steps out of order");

endmodule

`default_nettype wire

// ===== tb/tb_node_key_hash.sv =====
// Testbench for node_key_hash: random and directed key words against a built-in hash predictor.
`timescale 1ns / 1ps

module tb_node_key_hash;
    import nkh_pkg::*;

    // Run limit in clock cycles, far above the slowest correct run (every word
    // behind the longest gap, every hash behind the longest stall).
    localparam int CYCLE_LIMIT = 1500000;
    // About as many counted words as the random part should push.
    localparam int RANDOM_WORDS = 1900;
    // Drain time after the last hash.
    localparam int DRAIN_CYCLES = 24;

    // One input word as the block sees it, before packing.
    typedef struct {
        mode_t       mode;
        logic [31:0] key_word;
        logic [2:0]  byte_count;
        logic        last;
        logic [15:0] ns_idx;
    } key_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // [31:0] key_word, [34:32] byte_count,
                                       // [50:35] namespace, [55:51] zero
    logic                 s_tlast;
    logic [S_TUSER_W-1:0] s_tuser;     // [1:0] mode
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // [31:0] hash_value

    node_key_hash DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Words waiting to be driven, and the hashes owed by the block, oldest first.
    key_item_t   word_fifo[$];
    logic [31:0] hash_due[$];

    // Predictor copy of the block state.
    logic [31:0] acc_hash;
    logic [31:0] acc_len;
    logic        key_open;

    key_item_t   cur_word;      // word currently on the slave bus
    int          words_queued;  // counted words (unused mode excluded)
    int          cycles;
    int          err_count;
    int          in_gap;
    int          out_wait;
    bit          in_taken;
    bit          out_taken;

    //------------------------------------------------------------------
    // Hash arithmetic, written out from the algorithm description
    //------------------------------------------------------------------
    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = rol32(t, 15);
        t = t * MIX_C2;
        return t;
    endfunction

    function automatic logic [31:0] fold_block(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = h ^ scramble_word(k);
        t = rol32(t, 13) * 32'd5 + MIX_ADD;
        return t;
    endfunction

    function automatic logic [31:0] final_mix(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FIN_M1;
        t = t ^ (t >> 13);
        t = t * FIN_M2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    // Advance the state by one accepted word; queue the hash it completes, if any.
    task automatic predict_hash(input key_item_t it);
        logic [31:0] v;
        logic [31:0] msk;
        logic [2:0]  n;
        case (it.mode)
            MODE_NUMERIC:
            begin
                // numeric key also drops any array key in flight
                key_open = 1'b0;
                acc_hash = '0;
                acc_len  = '0;
                v = it.key_word + {16'h0, it.ns_idx};
                v = v * KNUTH_MUL;
                hash_due.push_back(v);
            end
            MODE_ABSENT:
            begin
                key_open = 1'b0;
                acc_hash = '0;
                acc_len  = '0;
                hash_due.push_back(32'h0);
            end
            MODE_ARRAY:
            begin
                // seed only on the first word; namespace ignored afterwards
                if (!key_open)
                begin
                    acc_hash = {16'h0, it.ns_idx};
                    acc_len  = '0;
                    key_open = 1'b1;
                end
                if (!it.last)
                begin
                    // non-last word: always 4 bytes, whatever byte_count says
                    acc_hash = fold_block(acc_hash, it.key_word);
                    acc_len  = acc_len + 32'd4;
                end
                else
                begin
                    n = (it.byte_count > 3'd4) ? 3'd4 : it.byte_count;
                    if (n == 3'd4)
                        acc_hash = fold_block(acc_hash, it.key_word);
                    else if (n != 3'd0)
                    begin
                        msk = (32'h1 << (8 * n)) - 32'h1;
                        acc_hash = acc_hash ^ scramble_word(it.key_word & msk);
                    end
                    acc_len = acc_len + {29'h0, n};
                    v = final_mix(acc_hash ^ acc_len);
                    hash_due.push_back(v);
                    acc_hash = '0;
                    acc_len  = '0;
                    key_open = 1'b0;
                end
            end
            default: ;  // unused mode: dropped, state untouched
        endcase
    endtask

    //------------------------------------------------------------------
    // Stimulus builders
    //------------------------------------------------------------------
    task automatic add_word(input mode_t md, input logic [31:0] kw, input logic [2:0] bc,
                            input logic lst, input logic [15:0] ns);
        key_item_t it;
        it.mode       = md;
        it.key_word   = kw;
        it.byte_count = bc;
        it.last       = lst;
        it.ns_idx     = ns;
        word_fifo.push_back(it);
        if (md != MODE_UNUSED)
            words_queued++;
    endtask

    function automatic logic [2:0] rand_tail_count();
        // mostly legal 0..4, with a share of saturating 5..7
        if ($urandom_range(0, 4) == 0)
            return 3'($urandom_range(5, 7));
        return 3'($urandom_range(0, 4));
    endfunction

    // Well-formed array key: nwords words, the last one carrying tail_cnt bytes.
    // Later words carry a different namespace, which the block must ignore.
    // With noisy set, unused-mode words get sprinkled between key words.
    task automatic add_key(input int nwords, input logic [2:0] tail_cnt, input bit noisy);
        logic [15:0] ns;
        int          i;
        ns = 16'($urandom);
        for (i = 0; i < nwords - 1; i++)
        begin
            add_word(MODE_ARRAY, $urandom, 3'($urandom_range(0, 7)), 1'b0,
                     (i == 0) ? ns : 16'($urandom));
            if (noisy && $urandom_range(0, 15) == 0)
                add_word(MODE_UNUSED, $urandom, 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), 16'($urandom));
        end
        add_word(MODE_ARRAY, $urandom, tail_cnt, 1'b1,
                 (nwords == 1) ? ns : 16'($urandom));
    endtask

    // Short directed list: field extremes, each mode, each corner of the key logic.
    task automatic add_directed();
        add_word(MODE_NUMERIC, 32'h0, 3'd0, 1'b1, 16'h0);
        add_word(MODE_NUMERIC, 32'hffffffff, 3'd7, 1'b1, 16'hffff);   // sum wraps
        add_word(MODE_ABSENT, 32'hffffffff, 3'd7, 1'b1, 16'hffff);
        add_word(MODE_UNUSED, 32'hdeadbeef, 3'd4, 1'b1, 16'h1234);    // dropped
        add_word(MODE_ARRAY, 32'hffffffff, 3'd0, 1'b1, 16'hffff);     // empty key
        add_word(MODE_ARRAY, 32'hffffffff, 3'd1, 1'b1, 16'h0001);
        add_word(MODE_ARRAY, 32'hffffffff, 3'd2, 1'b1, 16'h8000);
        add_word(MODE_ARRAY, 32'hffffffff, 3'd3, 1'b1, 16'h00ff);
        add_word(MODE_ARRAY, 32'h0, 3'd4, 1'b1, 16'h0);
        add_word(MODE_ARRAY, 32'hffffffff, 3'd7, 1'b1, 16'hffff);     // count saturates
        // non-last word with a short count still counts 4 bytes; second ns ignored
        add_word(MODE_ARRAY, 32'h03020100, 3'd2, 1'b0, 16'h0042);
        add_word(MODE_ARRAY, 32'h07060504, 3'd3, 1'b1, 16'hbeef);
        // key abandoned by a numeric word, then a fresh key
        add_word(MODE_ARRAY, 32'h11223344, 3'd4, 1'b0, 16'h0007);
        add_word(MODE_NUMERIC, 32'h00000001, 3'd4, 1'b0, 16'h0001);
        add_word(MODE_ARRAY, 32'h55667788, 3'd4, 1'b1, 16'h0009);
        // key abandoned by an absent word
        add_word(MODE_ARRAY, 32'h99aabbcc, 3'd5, 1'b0, 16'h0100);
        add_word(MODE_ABSENT, 32'h0, 3'd0, 1'b0, 16'h0);
        // unused mode inside a key must not disturb it
        add_word(MODE_ARRAY, 32'hcafef00d, 3'd4, 1'b0, 16'h0a0a);
        add_word(MODE_UNUSED, 32'h0, 3'd0, 1'b0, 16'h0);
        add_word(MODE_ARRAY, 32'h12345678, 3'd2, 1'b1, 16'h5555);
        // three-word key ending on a full word
        add_word(MODE_ARRAY, 32'h80000000, 3'd6, 1'b0, 16'h7fff);
        add_word(MODE_ARRAY, 32'h00000001, 3'd1, 1'b0, 16'h0);
        add_word(MODE_ARRAY, 32'haaaaaaaa, 3'd4, 1'b1, 16'h0);
    endtask

    task automatic add_random();
        int r;
        int n;
        int i;
        while (words_queued < RANDOM_WORDS + 25)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                // well-formed key: mostly short, a few long
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 4);
                add_key(n, rand_tail_count(), 1'b1);
            end
            else if (r < 80)
                add_word(MODE_NUMERIC, $urandom, 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), 16'($urandom));
            else if (r < 85)
                add_word(MODE_ABSENT, $urandom, 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), 16'($urandom));
            else if (r < 90)
                add_word(MODE_UNUSED, $urandom, 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), 16'($urandom));
            else
            begin
                // broken key: a few non-last words cut off by numeric or absent
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    add_word(MODE_ARRAY, $urandom, 3'($urandom_range(0, 7)), 1'b0,
                             16'($urandom));
                add_word($urandom_range(0, 1) ? MODE_NUMERIC : MODE_ABSENT, $urandom,
                         3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         16'($urandom));
            end
        end
    endtask

    // Idle length: mostly none or short, now and then long; quiet stretches with none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (cycles[10:8] == 3'd0)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    //------------------------------------------------------------------
    // Clock and reset
    //------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = '0;
        m_tready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    //------------------------------------------------------------------
    // Slave-side driver: one word at a time from word_fifo, changes on falling edge
    //------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (in_gap > 0)
            begin
                s_tvalid <= 1'b0;
                in_gap = in_gap - 1;
            end
            else if (word_fifo.size() > 0)
            begin
                cur_word = word_fifo.pop_front();
                s_tdata  <= {5'b0, cur_word.ns_idx, cur_word.byte_count, cur_word.key_word};
                s_tlast  <= cur_word.last;
                s_tuser  <= cur_word.mode;
                s_tvalid <= 1'b1;
                in_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Master-side ready: random stalls, started after a hash word or at random.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_wait > 0)
            begin
                m_tready <= 1'b0;
                out_wait = out_wait - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (out_taken || $urandom_range(0, 19) == 0)
                    out_wait = pick_gap();
            end
        end
    end

    //------------------------------------------------------------------
    // Monitor: sample both handshakes on the rising edge, predict and check
    //------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken  = rst_n && s_tvalid && s_tready;
        out_taken = rst_n && m_tvalid && m_tready;
        if (in_taken)
            predict_hash(cur_word);
        if (out_taken)
        begin
            if (hash_due.size() == 0)
            begin
                $error("hash_value: unexpected word, actual %08h", m_tdata);
                err_count++;
            end
            else
            begin
                if (m_tdata !== hash_due[0])
                begin
                    $error("hash_value: expected %08h, actual %08h", hash_due[0], m_tdata);
                    err_count++;
                end
                void'(hash_due.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_node_key_hash failed");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Sequence: build stimulus, wait for it to drain, report
    //------------------------------------------------------------------
    initial
    begin
        acc_hash     = '0;
        acc_len      = '0;
        key_open     = 1'b0;
        words_queued = 0;
        cycles       = 0;
        err_count    = 0;
        in_gap       = 0;
        out_wait     = 0;
        in_taken     = 1'b0;
        out_taken    = 1'b0;
        add_directed();
        add_random();
        @(posedge rst_n);
        while (word_fifo.size() != 0 || s_tvalid)
            @(posedge clk);
        while (hash_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (hash_due.size() != 0)
        begin
            $error("hash_value: %0d expected words never arrived", hash_due.size());
            err_count++;
        end
        if (err_count == 0)
            $display("tb_node_key_hash passed");
        else
            $display("tb_node_key_hash failed");
        $finish;
    end

endmodule
